/* sv/pthq_pkg.sv */
// Package for the periodic timer heap queue: sizes, field widths and codes.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package pthq_pkg;

  // Default sizes of the queue.
  localparam int unsigned CAPACITY  = 32;
  localparam int unsigned TIME_BITS = 48;

  // Fixed widths of the item fields.
  localparam int unsigned OP_BITS     = 2;
  localparam int unsigned HANDLE_BITS = 5;
  localparam int unsigned COUNT_BITS  = 6;
  localparam int unsigned KIND_BITS   = 2;
  localparam int unsigned STATUS_BITS = 2;

  // Operation codes of an input item.
  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT   = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_DISPATCH = 2'd2
  } op_e;

  // Kinds of result item.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_INS_ACK = 2'd0,
    KIND_CAN_ACK = 2'd1,
    KIND_FIRED   = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  // Status codes of a result item.
  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_NOT_PENDING = 2'd2
  } status_e;

endpackage

`default_nettype wire

/* sv/pthq_in_if.sv */
// Input channel of the timer queue: valid/ready handshake and the request fields.
// Depends on pthq_pkg for field widths.
`default_nettype none

interface pthq_in_if #(
  parameter int unsigned TimeBits = pthq_pkg::TIME_BITS
);
  logic                              valid;
  logic                              ready;
  logic [pthq_pkg::OP_BITS-1:0]      op;
  logic [TimeBits-1:0]               expiry_time;
  logic [TimeBits-1:0]               period;
  logic [pthq_pkg::HANDLE_BITS-1:0]  timer_handle;
  logic [TimeBits-1:0]               now;

  modport source (output valid, op, expiry_time, period, timer_handle, now, input ready);
  modport sink   (input valid, op, expiry_time, period, timer_handle, now, output ready);
endinterface

`default_nettype wire

/* sv/pthq_out_if.sv */
// Output channel of the timer queue: valid/ready handshake and the result fields.
// Depends on pthq_pkg for field widths.
`default_nettype none

interface pthq_out_if #(
  parameter int unsigned TimeBits = pthq_pkg::TIME_BITS
);
  logic                              valid;
  logic                              ready;
  logic [pthq_pkg::KIND_BITS-1:0]    kind;
  logic [pthq_pkg::HANDLE_BITS-1:0]  handle_out;
  logic [TimeBits-1:0]               due_time;
  logic [pthq_pkg::COUNT_BITS-1:0]   fired_count;
  logic [pthq_pkg::STATUS_BITS-1:0]  status;
  logic                              last;

  modport source (output valid, kind, handle_out, due_time, fired_count, status, last,
                  input ready);
  modport sink   (input valid, kind, handle_out, due_time, fired_count, status, last,
                  output ready);
endinterface

`default_nettype wire

/* sv/periodic_timer_heap_queue.sv */
// Timer queue kept as a binary min-heap of handles in synchronous memories.
// Depends on pthq_pkg, pthq_in_if and pthq_out_if.
//
//   Channel | Direction | Handshake     | Item
//   in_i    | sink      | valid & ready | op, expiry_time, period, timer_handle, now
//   out_o   | source    | valid & ready | kind, handle_out, due_time, fired_count, status, last
//
// One item is worked on at a time; in_i.ready is high only while the sequencer is idle.
// Insert takes a handle off the free stack and sifts it up one heap level at a time; cancel
// pops each dead entry off the top, sifting the last entry down from the root.
// Dispatch does a pop and, for a periodic timer, a push per fired timer. A compaction reads
// every heap entry, scans all Capacity handles to return them and rebuilds the heap.
// Reset needs no clearing pass; a stalled out_o holds the sequencer in place until the
// result register frees.
`default_nettype none

module periodic_timer_heap_queue #(
  parameter int unsigned Capacity = pthq_pkg::CAPACITY,
  parameter int unsigned TimeBits = pthq_pkg::TIME_BITS
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pthq_in_if.sink     in_i,
  pthq_out_if.source  out_o
);

  localparam int unsigned IW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned LW = IW + 1;
  localparam int unsigned HB = pthq_pkg::HANDLE_BITS;
  localparam logic [TimeBits-1:0] TMax = {TimeBits{1'b1}};

  // Sequencer states.
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_INS_GO  = 5'd1;
  localparam logic [4:0] S_SU_CHK  = 5'd2;
  localparam logic [4:0] S_SU_RS   = 5'd3;
  localparam logic [4:0] S_SU_RE   = 5'd4;
  localparam logic [4:0] S_SD_CHK  = 5'd5;
  localparam logic [4:0] S_SD_L1   = 5'd6;
  localparam logic [4:0] S_SD_L2   = 5'd7;
  localparam logic [4:0] S_SD_R1   = 5'd8;
  localparam logic [4:0] S_SD_R2   = 5'd9;
  localparam logic [4:0] S_SD_DEC  = 5'd10;
  localparam logic [4:0] S_LF_RS   = 5'd11;
  localparam logic [4:0] S_LF_RE   = 5'd12;
  localparam logic [4:0] S_POP     = 5'd13;
  localparam logic [4:0] S_TOP     = 5'd14;
  localparam logic [4:0] S_TOP_RS  = 5'd15;
  localparam logic [4:0] S_TOP_RE  = 5'd16;
  localparam logic [4:0] S_FIRE    = 5'd17;
  localparam logic [4:0] S_RESCHED = 5'd18;
  localparam logic [4:0] S_CP_CHK  = 5'd19;
  localparam logic [4:0] S_CP_RD   = 5'd20;
  localparam logic [4:0] S_CP_USE  = 5'd21;
  localparam logic [4:0] S_CP_REL  = 5'd22;
  localparam logic [4:0] S_HP      = 5'd23;
  localparam logic [4:0] S_EMIT    = 5'd24;

  // Heap order: earlier expiry first, lower handle on a tie.
  function automatic logic before_f(input logic [TimeBits-1:0] ea, input logic [IW-1:0] ha,
                                    input logic [TimeBits-1:0] eb, input logic [IW-1:0] hb);
    return (ea < eb) || ((ea == eb) && (ha < hb));
  endfunction

  // Control state.
  logic [4:0]           state_q, state_d, ret_q, ret_d;
  logic [CW-1:0]        heap_cnt_q, heap_cnt_d, free_cnt_q, free_cnt_d;
  logic [CW-1:0]        canc_cnt_q, canc_cnt_d, fired_q, fired_d;
  logic [CW-1:0]        cp_i_q, cp_i_d, cp_n_q, cp_n_d, hk_q, hk_d;
  logic [Capacity-1:0]  pending_q, pending_d, dead_q, dead_d, fvalid_q;
  logic                 dispatch_q, dispatch_d, best_self_q, best_self_d;
  logic [IW-1:0]        rel_q, rel_d;

  // Working registers.
  logic [TimeBits-1:0]  now_q, now_d, flt_e_q, flt_e_d, best_e_q, best_e_d;
  logic [TimeBits-1:0]  fe_q, fe_d, fp_q, fp_d;
  logic [IW-1:0]        flt_h_q, flt_h_d, idx_q, idx_d, best_h_q, best_h_d;
  logic [IW-1:0]        best_i_q, best_i_d, cand_h_q, cand_h_d, fh_q, fh_d;
  pthq_pkg::kind_e      res_kind_q, res_kind_d;
  pthq_pkg::status_e    res_status_q, res_status_d;
  logic [HB-1:0]        res_handle_q, res_handle_d;

  // Result register.
  logic                              out_valid_q;
  logic [pthq_pkg::KIND_BITS-1:0]    out_kind_q;
  logic [HB-1:0]                     out_handle_q;
  logic [TimeBits-1:0]               out_due_q;
  logic [pthq_pkg::COUNT_BITS-1:0]   out_cnt_q;
  logic [pthq_pkg::STATUS_BITS-1:0]  out_status_q;
  logic                              out_last_q;
  logic                              emit, can_emit;
  pthq_pkg::kind_e                   em_kind;
  logic [HB-1:0]                     em_handle;
  logic [TimeBits-1:0]               em_due;
  logic [pthq_pkg::COUNT_BITS-1:0]   em_cnt;
  pthq_pkg::status_e                 em_status;
  logic                              em_last;

  // Memories and their ports.
  logic [IW-1:0]        slot_mem [Capacity];
  logic [TimeBits-1:0]  exp_mem  [Capacity];
  logic [TimeBits-1:0]  per_mem  [Capacity];
  logic [IW-1:0]        free_mem [Capacity];
  logic                 slot_re, slot_we, hnd_re, exp_we, per_we, free_re, free_we;
  logic [IW-1:0]        slot_ra, slot_wa, slot_wd, hnd_ra, hnd_wa, free_ra, free_wa, free_wd;
  logic [TimeBits-1:0]  exp_wd, per_wd;
  logic [IW-1:0]        slot_rd_q, free_rd_q;
  logic [TimeBits-1:0]  exp_rd_q, per_rd_q;

  // Release of a handle to the free stack.
  logic                 rel_en;
  logic [IW-1:0]        rel_h;

  // Derived values.
  logic [LW-1:0]        child_l, child_r, heap_cnt_ext;
  logic [CW-1:0]        cnt_m1;
  logic [TimeBits:0]    resched_sum;
  logic [TimeBits-1:0]  resched_s, resched_t, resched_e;

  assign child_l      = {idx_q, 1'b1};
  assign child_r      = child_l + LW'(1);
  assign heap_cnt_ext = LW'(heap_cnt_q);
  assign cnt_m1       = heap_cnt_q - CW'(1);
  assign can_emit     = !out_valid_q || out_o.ready;

  // Next expiry of a periodic timer: max(expiry + period, now + 1), saturating.
  assign resched_sum = {1'b0, fe_q} + {1'b0, fp_q};
  assign resched_s   = resched_sum[TimeBits] ? TMax : resched_sum[TimeBits-1:0];
  assign resched_t   = (now_q == TMax) ? TMax : now_q + TimeBits'(1);
  assign resched_e   = (resched_s > resched_t) ? resched_s : resched_t;

  assign in_i.ready = (state_q == S_IDLE);

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    heap_cnt_d   = heap_cnt_q;
    free_cnt_d   = free_cnt_q;
    canc_cnt_d   = canc_cnt_q;
    fired_d      = fired_q;
    cp_i_d       = cp_i_q;
    cp_n_d       = cp_n_q;
    hk_d         = hk_q;
    pending_d    = pending_q;
    dead_d       = dead_q;
    dispatch_d   = dispatch_q;
    best_self_d  = best_self_q;
    rel_d        = rel_q;
    now_d        = now_q;
    flt_e_d      = flt_e_q;
    best_e_d     = best_e_q;
    fe_d         = fe_q;
    fp_d         = fp_q;
    flt_h_d      = flt_h_q;
    idx_d        = idx_q;
    best_h_d     = best_h_q;
    best_i_d     = best_i_q;
    cand_h_d     = cand_h_q;
    fh_d         = fh_q;
    res_kind_d   = res_kind_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    slot_re = 1'b0;  slot_ra = '0;
    slot_we = 1'b0;  slot_wa = '0;  slot_wd = '0;
    hnd_re  = 1'b0;  hnd_ra  = '0;
    exp_we  = 1'b0;  per_we  = 1'b0;  hnd_wa = '0;
    exp_wd  = '0;    per_wd  = '0;
    free_re = 1'b0;  free_ra = '0;
    free_we = 1'b0;  free_wa = '0;  free_wd = '0;
    rel_en  = 1'b0;  rel_h   = '0;
    emit      = 1'b0;
    em_kind   = pthq_pkg::KIND_INS_ACK;
    em_handle = '0;
    em_due    = '0;
    em_cnt    = '0;
    em_status = pthq_pkg::ST_OK;
    em_last   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          dispatch_d   = 1'b0;
          res_status_d = pthq_pkg::ST_OK;
          res_handle_d = '0;
          if (in_i.op == pthq_pkg::OP_INSERT) begin
            res_kind_d = pthq_pkg::KIND_INS_ACK;
            if (free_cnt_q == '0) begin
              res_status_d = pthq_pkg::ST_FULL;
              state_d      = S_EMIT;
            end else begin
              free_re = 1'b1;
              free_ra = IW'(free_cnt_q - CW'(1));
              flt_e_d = in_i.expiry_time;
              fp_d    = in_i.period;
              state_d = S_INS_GO;
            end
          end else if (in_i.op == pthq_pkg::OP_CANCEL) begin
            res_kind_d   = pthq_pkg::KIND_CAN_ACK;
            res_handle_d = in_i.timer_handle;
            if ((int'(in_i.timer_handle) >= Capacity) ||
                !pending_q[IW'(in_i.timer_handle)]) begin
              res_status_d = pthq_pkg::ST_NOT_PENDING;
              state_d      = S_EMIT;
            end else begin
              pending_d[IW'(in_i.timer_handle)] = 1'b0;
              canc_cnt_d = canc_cnt_q + CW'(1);
              state_d    = S_TOP;
            end
          end else if (in_i.op == pthq_pkg::OP_DISPATCH) begin
            res_kind_d = pthq_pkg::KIND_DONE;
            dispatch_d = 1'b1;
            now_d      = in_i.now;
            fired_d    = '0;
            state_d    = S_TOP;
          end
        end
      end

      // Schedule the new timer under the handle taken from the free stack.
      S_INS_GO: begin
        exp_we = 1'b1;
        per_we = 1'b1;
        hnd_wa = free_rd_q;
        exp_wd = flt_e_q;
        per_wd = fp_q;
        pending_d[free_rd_q] = 1'b1;
        free_cnt_d   = free_cnt_q - CW'(1);
        res_handle_d = HB'(free_rd_q);
        flt_h_d      = free_rd_q;
        idx_d        = IW'(heap_cnt_q);
        heap_cnt_d   = heap_cnt_q + CW'(1);
        ret_d        = S_EMIT;
        state_d      = S_SU_CHK;
      end

      // Sift up: the floating handle climbs while it orders before its parent.
      S_SU_CHK: begin
        if (idx_q == '0) begin
          slot_we = 1'b1;
          slot_wa = idx_q;
          slot_wd = flt_h_q;
          state_d = ret_q;
        end else begin
          best_i_d = (idx_q - IW'(1)) >> 1;
          slot_re  = 1'b1;
          slot_ra  = (idx_q - IW'(1)) >> 1;
          state_d  = S_SU_RS;
        end
      end
      S_SU_RS: begin
        cand_h_d = slot_rd_q;
        hnd_re   = 1'b1;
        hnd_ra   = slot_rd_q;
        state_d  = S_SU_RE;
      end
      S_SU_RE: begin
        slot_we = 1'b1;
        slot_wa = idx_q;
        if (before_f(flt_e_q, flt_h_q, exp_rd_q, cand_h_q)) begin
          slot_wd = cand_h_q;
          idx_d   = best_i_q;
          state_d = S_SU_CHK;
        end else begin
          slot_wd = flt_h_q;
          state_d = ret_q;
        end
      end

      // Sift down: the floating handle sinks below the smaller of its children.
      S_SD_CHK: begin
        best_h_d    = flt_h_q;
        best_e_d    = flt_e_q;
        best_self_d = 1'b1;
        if (child_l < heap_cnt_ext) begin
          slot_re = 1'b1;
          slot_ra = IW'(child_l);
          state_d = S_SD_L1;
        end else begin
          slot_we = 1'b1;
          slot_wa = idx_q;
          slot_wd = flt_h_q;
          state_d = ret_q;
        end
      end
      S_SD_L1: begin
        cand_h_d = slot_rd_q;
        hnd_re   = 1'b1;
        hnd_ra   = slot_rd_q;
        state_d  = S_SD_L2;
      end
      S_SD_L2: begin
        if (before_f(exp_rd_q, cand_h_q, best_e_q, best_h_q)) begin
          best_h_d    = cand_h_q;
          best_e_d    = exp_rd_q;
          best_i_d    = IW'(child_l);
          best_self_d = 1'b0;
        end
        if (child_r < heap_cnt_ext) begin
          slot_re = 1'b1;
          slot_ra = IW'(child_r);
          state_d = S_SD_R1;
        end else begin
          state_d = S_SD_DEC;
        end
      end
      S_SD_R1: begin
        cand_h_d = slot_rd_q;
        hnd_re   = 1'b1;
        hnd_ra   = slot_rd_q;
        state_d  = S_SD_R2;
      end
      S_SD_R2: begin
        if (before_f(exp_rd_q, cand_h_q, best_e_q, best_h_q)) begin
          best_h_d    = cand_h_q;
          best_e_d    = exp_rd_q;
          best_i_d    = IW'(child_r);
          best_self_d = 1'b0;
        end
        state_d = S_SD_DEC;
      end
      S_SD_DEC: begin
        slot_we = 1'b1;
        slot_wa = idx_q;
        if (best_self_q) begin
          slot_wd = flt_h_q;
          state_d = ret_q;
        end else begin
          slot_wd = best_h_q;
          idx_d   = best_i_q;
          state_d = S_SD_CHK;
        end
      end

      // Load the floating handle and its expiry, then sift down from idx.
      S_LF_RS: begin
        flt_h_d = slot_rd_q;
        hnd_re  = 1'b1;
        hnd_ra  = slot_rd_q;
        state_d = S_LF_RE;
      end
      S_LF_RE: begin
        flt_e_d = exp_rd_q;
        state_d = S_SD_CHK;
      end

      // Pop the top: the last entry floats down from the root.
      S_POP: begin
        heap_cnt_d = cnt_m1;
        if (cnt_m1 == '0) begin
          state_d = ret_q;
        end else begin
          slot_re = 1'b1;
          slot_ra = IW'(cnt_m1);
          idx_d   = '0;
          state_d = S_LF_RS;
        end
      end

      // Look at the top: drop cancelled entries, fire due timers when dispatching.
      S_TOP: begin
        if (heap_cnt_q == '0) begin
          state_d = S_CP_CHK;
        end else begin
          slot_re = 1'b1;
          slot_ra = '0;
          state_d = S_TOP_RS;
        end
      end
      S_TOP_RS: begin
        cand_h_d = slot_rd_q;
        if (!pending_q[slot_rd_q]) begin
          rel_en = 1'b1;
          rel_h  = slot_rd_q;
          if (canc_cnt_q != '0) begin
            canc_cnt_d = canc_cnt_q - CW'(1);
          end
          ret_d   = S_TOP;
          state_d = S_POP;
        end else if (!dispatch_q) begin
          state_d = S_CP_CHK;
        end else begin
          hnd_re  = 1'b1;
          hnd_ra  = slot_rd_q;
          state_d = S_TOP_RE;
        end
      end
      S_TOP_RE: begin
        if ((exp_rd_q <= now_q) && (fired_q < CW'(Capacity))) begin
          fh_d    = cand_h_q;
          fe_d    = exp_rd_q;
          fp_d    = per_rd_q;
          state_d = S_FIRE;
        end else begin
          state_d = S_CP_CHK;
        end
      end
      S_FIRE: begin
        if (can_emit) begin
          emit      = 1'b1;
          em_kind   = pthq_pkg::KIND_FIRED;
          em_handle = HB'(fh_q);
          em_due    = fe_q;
          fired_d   = fired_q + CW'(1);
          ret_d     = S_RESCHED;
          state_d   = S_POP;
        end
      end
      S_RESCHED: begin
        if (fp_q != '0) begin
          exp_we     = 1'b1;
          hnd_wa     = fh_q;
          exp_wd     = resched_e;
          flt_h_d    = fh_q;
          flt_e_d    = resched_e;
          idx_d      = IW'(heap_cnt_q);
          heap_cnt_d = heap_cnt_q + CW'(1);
          ret_d      = S_TOP;
          state_d    = S_SU_CHK;
        end else begin
          rel_en  = 1'b1;
          rel_h   = fh_q;
          state_d = S_TOP;
        end
      end

      // Compaction: squeeze out cancelled entries, free them in order, rebuild.
      S_CP_CHK: begin
        if (canc_cnt_q > (heap_cnt_q >> 1)) begin
          cp_i_d  = '0;
          cp_n_d  = '0;
          state_d = S_CP_RD;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_CP_RD: begin
        if (cp_i_q == heap_cnt_q) begin
          heap_cnt_d = cp_n_q;
          rel_d      = '0;
          state_d    = S_CP_REL;
        end else begin
          slot_re = 1'b1;
          slot_ra = IW'(cp_i_q);
          state_d = S_CP_USE;
        end
      end
      S_CP_USE: begin
        if (pending_q[slot_rd_q]) begin
          slot_we = 1'b1;
          slot_wa = IW'(cp_n_q);
          slot_wd = slot_rd_q;
          cp_n_d  = cp_n_q + CW'(1);
        end else begin
          dead_d[slot_rd_q] = 1'b1;
        end
        cp_i_d  = cp_i_q + CW'(1);
        state_d = S_CP_RD;
      end
      S_CP_REL: begin
        if (dead_q[rel_q]) begin
          rel_en        = 1'b1;
          rel_h         = rel_q;
          dead_d[rel_q] = 1'b0;
        end
        if (rel_q == IW'(Capacity - 1)) begin
          hk_d    = heap_cnt_q >> 1;
          state_d = S_HP;
        end else begin
          rel_d = rel_q + IW'(1);
        end
      end
      S_HP: begin
        if (hk_q == '0) begin
          canc_cnt_d = '0;
          state_d    = S_EMIT;
        end else begin
          idx_d   = IW'(hk_q - CW'(1));
          slot_re = 1'b1;
          slot_ra = IW'(hk_q - CW'(1));
          hk_d    = hk_q - CW'(1);
          ret_d   = S_HP;
          state_d = S_LF_RS;
        end
      end

      // Final result of the item.
      S_EMIT: begin
        if (can_emit) begin
          emit      = 1'b1;
          em_kind   = res_kind_q;
          em_handle = res_handle_q;
          em_status = res_status_q;
          em_last   = 1'b1;
          if (res_kind_q == pthq_pkg::KIND_DONE) begin
            em_cnt = pthq_pkg::COUNT_BITS'(fired_q);
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A released handle loses its mark and goes back on the free stack.
    if (rel_en) begin
      pending_d[rel_h] = 1'b0;
      if (free_cnt_q < CW'(Capacity)) begin
        free_we    = 1'b1;
        free_wa    = IW'(free_cnt_q);
        free_wd    = rel_h;
        free_cnt_d = free_cnt_q + CW'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      heap_cnt_q  <= '0;
      free_cnt_q  <= CW'(Capacity);
      canc_cnt_q  <= '0;
      fired_q     <= '0;
      pending_q   <= '0;
      dead_q      <= '0;
      fvalid_q    <= '0;
      dispatch_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      heap_cnt_q <= heap_cnt_d;
      free_cnt_q <= free_cnt_d;
      canc_cnt_q <= canc_cnt_d;
      fired_q    <= fired_d;
      pending_q  <= pending_d;
      dead_q     <= dead_d;
      dispatch_q <= dispatch_d;
      if (free_we) begin
        fvalid_q[free_wa] <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    cp_i_q       <= cp_i_d;
    cp_n_q       <= cp_n_d;
    hk_q         <= hk_d;
    best_self_q  <= best_self_d;
    rel_q        <= rel_d;
    now_q        <= now_d;
    flt_e_q      <= flt_e_d;
    best_e_q     <= best_e_d;
    fe_q         <= fe_d;
    fp_q         <= fp_d;
    flt_h_q      <= flt_h_d;
    idx_q        <= idx_d;
    best_h_q     <= best_h_d;
    best_i_q     <= best_i_d;
    cand_h_q     <= cand_h_d;
    fh_q         <= fh_d;
    res_kind_q   <= res_kind_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    if (emit) begin
      out_kind_q   <= em_kind;
      out_handle_q <= em_handle;
      out_due_q    <= em_due;
      out_cnt_q    <= em_cnt;
      out_status_q <= em_status;
      out_last_q   <= em_last;
    end
  end

  // Heap of handles.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_ra];
    end
  end

  // Expiry and period per handle, read together.
  always_ff @(posedge clk_i) begin
    if (exp_we) begin
      exp_mem[hnd_wa] <= exp_wd;
    end
    if (per_we) begin
      per_mem[hnd_wa] <= per_wd;
    end
    if (hnd_re) begin
      exp_rd_q <= exp_mem[hnd_ra];
      per_rd_q <= per_mem[hnd_ra];
    end
  end

  // Free stack; an entry never written holds its reset handle.
  always_ff @(posedge clk_i) begin
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    if (free_re) begin
      free_rd_q <= fvalid_q[free_ra] ? free_mem[free_ra] : IW'(Capacity - 1) - free_ra;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.handle_out  = out_handle_q;
  assign out_o.due_time    = out_due_q;
  assign out_o.fired_count = out_cnt_q;
  assign out_o.status      = out_status_q;
  assign out_o.last        = out_last_q;

endmodule

`default_nettype wire

/* sv/pthq_checker.sv */
// Port checker for the timer queue, bound to the top level below.
// Depends on pthq_pkg for codes and widths.
`default_nettype none

module pthq_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [pthq_pkg::KIND_BITS-1:0]    kind_i,
  input wire logic [pthq_pkg::HANDLE_BITS-1:0]  handle_out_i,
  input wire logic [pthq_pkg::STATUS_BITS-1:0]  status_i,
  input wire logic                              last_i
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A fired timer is never the final result of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == pthq_pkg::KIND_FIRED) |-> !last_i)
    else $error("fired result marked last");

  // Every other kind closes its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != pthq_pkg::KIND_FIRED) |-> last_i)
    else $error("closing result not marked last");

  // A full queue answers only an insert, with handle zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == pthq_pkg::ST_FULL) |->
      (kind_i == pthq_pkg::KIND_INS_ACK) && (handle_out_i == '0))
    else $error("full status on a wrong result");

  // Not-pending status belongs to a cancel ack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == pthq_pkg::ST_NOT_PENDING) |->
      (kind_i == pthq_pkg::KIND_CAN_ACK))
    else $error("not-pending status on a wrong result");

endmodule

bind periodic_timer_heap_queue pthq_checker u_pthq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .kind_i       (out_o.kind),
  .handle_out_i (out_o.handle_out),
  .status_i     (out_o.status),
  .last_i       (out_o.last)
);

`default_nettype wire

/* tb/tb_periodic_timer_heap_queue.sv */
// Testbench for the periodic timer heap queue: random and directed timer operations,
// checked against a behavioral timer-queue predictor. Depends on pthq_pkg, pthq_in_if,
// pthq_out_if and periodic_timer_heap_queue.
`default_nettype none

module tb_periodic_timer_heap_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NT = pthq_pkg::CAPACITY;
  localparam logic [47:0] TMAX = '1;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    pthq_pkg::op_e op;
    logic [47:0]   expiry;
    logic [47:0]   period;
    logic [4:0]    handle;
    logic [47:0]   now;
  } request_t;

  typedef struct packed {
    pthq_pkg::kind_e   kind;
    logic [4:0]        handle;
    logic [47:0]       due;
    logic [5:0]        count;
    pthq_pkg::status_e status;
    logic              last;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pthq_in_if  in_ch ();
  pthq_out_if out_ch ();

  periodic_timer_heap_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Timer queue state mirrored by the predictor.
  logic [4:0]  tq_heap [NT];
  int          tq_heap_n;
  logic [47:0] tq_expiry [NT];
  logic [47:0] tq_period [NT];
  bit          tq_pending [NT];
  logic [4:0]  tq_free [NT];
  int          tq_free_n;
  int          tq_cancelled;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int       errors = 0;
  int       cycle = 0;
  int       answers_seen = 0;
  int       fired_seen = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_off = 0;

  function automatic bit earlier(logic [4:0] a, logic [4:0] b);
    if (tq_expiry[a] != tq_expiry[b]) return tq_expiry[a] < tq_expiry[b];
    return a < b;
  endfunction

  function automatic void sift_down(int i);
    int l, r, m;
    logic [4:0] t;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < tq_heap_n && earlier(tq_heap[l], tq_heap[m])) m = l;
      if (r < tq_heap_n && earlier(tq_heap[r], tq_heap[m])) m = r;
      if (m == i) break;
      t = tq_heap[i]; tq_heap[i] = tq_heap[m]; tq_heap[m] = t;
      i = m;
    end
  endfunction

  function automatic void heap_insert(logic [4:0] h);
    int i, p;
    logic [4:0] t;
    if (tq_heap_n >= NT) return;
    tq_heap[tq_heap_n] = h;
    i = tq_heap_n;
    tq_heap_n++;
    while (i > 0) begin
      p = (i - 1) >> 1;
      if (!earlier(tq_heap[i], tq_heap[p])) break;
      t = tq_heap[i]; tq_heap[i] = tq_heap[p]; tq_heap[p] = t;
      i = p;
    end
  endfunction

  function automatic logic [4:0] heap_take_top();
    logic [4:0] h;
    h = tq_heap[0];
    tq_heap_n--;
    tq_heap[0] = tq_heap[tq_heap_n];
    sift_down(0);
    return h;
  endfunction

  function automatic void free_handle(logic [4:0] h);
    tq_pending[h] = 0;
    if (tq_free_n < NT) begin
      tq_free[tq_free_n] = h;
      tq_free_n++;
    end
  endfunction

  function automatic void drop_dead_top();
    while (tq_heap_n > 0 && !tq_pending[tq_heap[0]]) begin
      free_handle(heap_take_top());
      if (tq_cancelled > 0) tq_cancelled--;
    end
  endfunction

  // Remove all cancelled entries once they outnumber half the heap.
  function automatic void compact_heap();
    bit dead [NT];
    int n;
    if (tq_cancelled <= (tq_heap_n >> 1)) return;
    n = 0;
    for (int i = 0; i < NT; i++) dead[i] = 0;
    for (int i = 0; i < tq_heap_n; i++) begin
      if (tq_pending[tq_heap[i]]) begin
        tq_heap[n] = tq_heap[i];
        n++;
      end else begin
        dead[tq_heap[i]] = 1;
      end
    end
    tq_heap_n = n;
    for (int i = 0; i < NT; i++) if (dead[i]) free_handle(5'(i));
    for (int i = tq_heap_n >> 1; i > 0; i--) sift_down(i - 1);
    tq_cancelled = 0;
  endfunction

  function automatic void queue_answer(pthq_pkg::kind_e k, logic [4:0] h, logic [47:0] d,
                                       logic [5:0] c, pthq_pkg::status_e s, logic l);
    answer_t a;
    a.kind = k; a.handle = h; a.due = d; a.count = c; a.status = s; a.last = l;
    expected_answers.insert(expected_answers.size(), a);
  endfunction

  function automatic void timer_queue_step(request_t rq);
    logic [4:0]  h;
    logic [47:0] e, lim;
    logic [48:0] sum;
    int n;
    case (rq.op)
      pthq_pkg::OP_INSERT: begin
        if (tq_free_n == 0) begin
          queue_answer(pthq_pkg::KIND_INS_ACK, 5'd0, '0, '0, pthq_pkg::ST_FULL, 1'b1);
        end else begin
          tq_free_n--;
          h = tq_free[tq_free_n];
          tq_expiry[h] = rq.expiry;
          tq_period[h] = rq.period;
          tq_pending[h] = 1;
          heap_insert(h);
          queue_answer(pthq_pkg::KIND_INS_ACK, h, '0, '0, pthq_pkg::ST_OK, 1'b1);
        end
      end
      pthq_pkg::OP_CANCEL: begin
        h = rq.handle;
        if (!tq_pending[h]) begin
          queue_answer(pthq_pkg::KIND_CAN_ACK, h, '0, '0, pthq_pkg::ST_NOT_PENDING, 1'b1);
        end else begin
          tq_pending[h] = 0;
          tq_cancelled++;
          drop_dead_top();
          compact_heap();
          queue_answer(pthq_pkg::KIND_CAN_ACK, h, '0, '0, pthq_pkg::ST_OK, 1'b1);
        end
      end
      pthq_pkg::OP_DISPATCH: begin
        n = 0;
        while (tq_heap_n > 0) begin
          h = tq_heap[0];
          if (!tq_pending[h]) begin
            free_handle(heap_take_top());
            if (tq_cancelled > 0) tq_cancelled--;
          end else if (tq_expiry[h] <= rq.now && n < NT) begin
            e = tq_expiry[h];
            void'(heap_take_top());
            queue_answer(pthq_pkg::KIND_FIRED, h, e, '0, pthq_pkg::ST_OK, 1'b0);
            n++;
            if (tq_period[h] != 0) begin
              // Reschedule, saturating at the largest time, never at or before now.
              sum = {1'b0, e} + {1'b0, tq_period[h]};
              lim = (rq.now == TMAX) ? TMAX : rq.now + 48'd1;
              if (sum[48]) sum = {1'b0, TMAX};
              tq_expiry[h] = (sum[47:0] > lim) ? sum[47:0] : lim;
              heap_insert(h);
            end else begin
              free_handle(h);
            end
          end else begin
            break;
          end
        end
        compact_heap();
        queue_answer(pthq_pkg::KIND_DONE, 5'd0, '0, 6'(n), pthq_pkg::ST_OK, 1'b1);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle, what, got, want);
  endtask

  function automatic request_t make_request(pthq_pkg::op_e op, logic [47:0] ex,
                                            logic [47:0] per, logic [4:0] h,
                                            logic [47:0] nw);
    request_t r;
    r.op = op; r.expiry = ex; r.period = per; r.handle = h; r.now = nw;
    return r;
  endfunction

  // Appends one item to the queue of pending requests.
  function automatic void queue_request(request_t r);
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  function automatic logic [47:0] rand_time();
    return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
  endfunction

  // Driver: presents queued requests, idling at random, and predicts on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= pthq_pkg::OP_INSERT;
      in_ch.expiry_time <= '0;
      in_ch.period <= '0;
      in_ch.timer_handle <= '0;
      in_ch.now <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        timer_queue_step(pending_requests.pop_front());
      end
      if ((!in_ch.valid || in_ch.ready) && pending_requests.size() > 0) begin
        if ($urandom_range(99) >= send_idle_pct) begin
          request_t r;
          r = pending_requests[0];
          in_ch.valid <= 1'b1;
          in_ch.op <= r.op;
          in_ch.expiry_time <= r.expiry;
          in_ch.period <= r.period;
          in_ch.timer_handle <= r.handle;
          in_ch.now <= r.now;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end else if (in_ch.valid && in_ch.ready) begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stall control, with an optional long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      answers_seen <= answers_seen + 1;
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected result kind", 64'(out_ch.kind), 64'hx);
      end else begin
        answer_t w;
        w = expected_answers.pop_front();
        if (w.kind == pthq_pkg::KIND_FIRED) fired_seen <= fired_seen + 1;
        if (out_ch.kind != w.kind) report_mismatch("kind", 64'(out_ch.kind), 64'(w.kind));
        if (out_ch.handle_out != w.handle)
          report_mismatch("handle_out", 64'(out_ch.handle_out), 64'(w.handle));
        if (out_ch.due_time != w.due)
          report_mismatch("due_time", 64'(out_ch.due_time), 64'(w.due));
        if (out_ch.fired_count != w.count)
          report_mismatch("fired_count", 64'(out_ch.fired_count), 64'(w.count));
        if (out_ch.status != w.status)
          report_mismatch("status", 64'(out_ch.status), 64'(w.status));
        if (out_ch.last != w.last) report_mismatch("last", 64'(out_ch.last), 64'(w.last));
      end
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    if (cycle > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("tb_periodic_timer_heap_queue: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() > 0 || in_ch.valid || expected_answers.size() > 0)
      @(posedge clk_i);
  endtask

  // Random phase: inserts, mostly with small times, cancels of random handles, and dispatches.
  task automatic add_random(int count);
    int sel;
    logic [47:0] base;
    base = 48'd1000;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        if ($urandom_range(9) == 0)
          queue_request(make_request(pthq_pkg::OP_INSERT, rand_time(), rand_time(), 0, 0));
        else
          queue_request(make_request(pthq_pkg::OP_INSERT,
            base + 48'($urandom_range(2000)),
            ($urandom_range(2) == 0) ? 48'd0 : 48'($urandom_range(1500)), 0, 0));
      end else if (sel < 70) begin
        queue_request(make_request(pthq_pkg::OP_CANCEL, 0, 0, 5'($urandom), 0));
      end else if (sel < 97) begin
        base = base + 48'($urandom_range(800));
        queue_request(make_request(pthq_pkg::OP_DISPATCH, 0, 0, 0, base));
      end else begin
        queue_request(make_request(pthq_pkg::OP_DISPATCH, 0, 0, 0, rand_time()));
      end
    end
  endtask

  initial begin
    tq_heap_n = 0;
    tq_free_n = NT;
    tq_cancelled = 0;
    for (int i = 0; i < NT; i++) begin
      tq_free[i] = 5'(NT - 1 - i);
      tq_pending[i] = 0;
      tq_expiry[i] = '0;
      tq_period[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, bad cancel, ties, saturating reschedule, periodic timers.
    queue_request(make_request(pthq_pkg::OP_CANCEL, 0, 0, 5'd31, 0));
    queue_request(make_request(pthq_pkg::OP_DISPATCH, 0, 0, 0, 48'd0));
    queue_request(make_request(pthq_pkg::OP_INSERT, TMAX, TMAX, 5'd31, TMAX));
    queue_request(make_request(pthq_pkg::OP_INSERT, 48'd5, 48'd0, 0, 0));
    queue_request(make_request(pthq_pkg::OP_INSERT, 48'd5, 48'd3, 0, 0));
    queue_request(make_request(pthq_pkg::OP_INSERT, 48'd0, 48'd100, 0, 0));
    queue_request(make_request(pthq_pkg::OP_DISPATCH, 0, 0, 0, 48'd10));
    queue_request(make_request(pthq_pkg::OP_CANCEL, 0, 0, 5'd2, 0));
    queue_request(make_request(pthq_pkg::OP_CANCEL, 0, 0, 5'd2, 0));
    queue_request(make_request(pthq_pkg::OP_DISPATCH, 0, 0, 0, TMAX));
    queue_request(make_request(pthq_pkg::OP_DISPATCH, 0, 0, 0, TMAX));
    for (int i = 0; i < 14; i++)
      queue_request(make_request(pthq_pkg::OP_INSERT, 48'(i * 7), 48'(i), 0, 0));
    wait_drained();

    // Fill to capacity and go past it, then dispatch everything.
    for (int i = 0; i < 36; i++)
      queue_request(make_request(pthq_pkg::OP_INSERT, 48'(100 + $urandom_range(50)),
                                 48'd0, 0, 0));
    queue_request(make_request(pthq_pkg::OP_DISPATCH, 0, 0, 0, TMAX));
    wait_drained();

    // Random phases with different idling mixes; a long receiver hold-off in the first.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (ph == 0) hold_off = 400;
      add_random(25);
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (100) @(posedge clk_i);

    $display("covered %0d results, %0d timers fired, idling phases and a long output stall",
             answers_seen, fired_seen);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("tb_periodic_timer_heap_queue: done, clean");
    end else begin
      $display("tb_periodic_timer_heap_queue: done, errors");
    end
    $finish;
  end
endmodule

`default_nettype wire
